// File: rtl/core/stlb_pkg.sv
package stlb_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned LEN_W           = 11;
  localparam int unsigned VAL_W           = 32;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [IDX_W-1:0]  entry_index;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  // IEEE a >= b; false when either is NaN, -0 equals +0
  function automatic logic fp_ge(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    logic a_zero;
    logic b_zero;
    logic res;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (a_nan || b_nan) begin
      res = 1'b0;
    end else if (a_zero && b_zero) begin
      res = 1'b1;
    end else if (a[31] != b[31]) begin
      res = b[31];
    end else if (!a[31]) begin
      res = (a[30:0] >= b[30:0]);
    end else begin
      res = (a[30:0] <= b[30:0]);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/stlb_front.sv
module stlb_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  stlb_pkg::cmd_t in_cmd,
  output logic           q_valid,
  input  logic           q_ready,
  output stlb_pkg::cmd_t q_cmd
);
  import stlb_pkg::*;

  // two-entry queue
  cmd_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an item");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop)
    else $error("pop from empty queue");
endmodule

// File: rtl/core/stlb_back.sv
module stlb_back #(
  parameter int unsigned TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [stlb_pkg::LEN_W-1:0] table_length,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  stlb_pkg::cmd_t             q_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [stlb_pkg::LEN_W-1:0] out_position
);
  import stlb_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP
  } state_t;

  logic [VAL_W-1:0] table_r [TABLE_DEPTH];
  logic [VAL_W-1:0] rdata_r;
  state_t           state_r;
  logic [PW-1:0]    left_r;
  logic [PW-1:0]    right_r;
  logic [PW-1:0]    mid;
  logic [VAL_W-1:0] key_r;
  logic             out_valid_r;
  logic [LEN_W-1:0] pos_r;
  logic [PW-1:0]    len_sat;
  logic [PW:0]      span;

  always_comb begin
    if ((PW+LEN_W)'(table_length) > (PW+LEN_W)'(TABLE_DEPTH)) begin
      len_sat = PW'(TABLE_DEPTH);
    end else begin
      len_sat = PW'(table_length);
    end
  end

  assign span    = {1'b0, right_r} - {1'b0, left_r};
  assign mid     = left_r + PW'(span >> 1);
  assign q_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_position = pos_r;

  always_ff @(posedge clk) begin
    rdata_r <= table_r[mid[AW-1:0]];
    if (q_valid && q_ready && q_cmd.action == ACT_LOAD &&
        {{PW{1'b0}}, q_cmd.entry_index} < (PW+IDX_W)'(TABLE_DEPTH)) begin
      table_r[q_cmd.entry_index[AW-1:0]] <= q_cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      right_r     <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_ready && q_cmd.action == ACT_QUERY) begin
            key_r   <= q_cmd.value;
            left_r  <= '0;
            right_r <= len_sat;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (left_r == right_r) begin
            pos_r       <= LEN_W'(left_r);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (fp_ge(rdata_r, key_r)) begin
            right_r <= mid;
          end else begin
            left_r <= mid + PW'(1);
          end
          state_r <= S_READ;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) left_r <= right_r)
    else $error("bisection bounds crossed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result while searching");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |=> (state_r == S_READ))
    else $error("compare step not followed by read");
endmodule

// File: rtl/core/sorted_table_lower_bound.sv
// Channel | Direction | Ports
// in_     | input     | in_valid, in_ready, in_action, in_entry_index, in_value
// out_    | output    | out_valid, out_ready, out_position
// cfg_    | input     | cfg_we, cfg_table_length
// In the search engine a query runs s bisection steps, each one table read and one compare,
// floor(log2(len+1)) <= s <= ceil(log2(len+1)), then a final read state returns the position.
// A load is written when the engine takes it; items pass through the registered queue first.
// A two-entry queue takes items while the engine searches or a result waits.
// Reset (rst_n low, synchronous) clears control and table_length; table contents
// stay undefined until loaded.
module sorted_table_lower_bound #(
  parameter int unsigned TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [stlb_pkg::IDX_W-1:0] in_entry_index,
  input  logic [stlb_pkg::VAL_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [stlb_pkg::LEN_W-1:0] out_position,
  input  logic                       cfg_we,
  input  logic [stlb_pkg::LEN_W-1:0] cfg_table_length
);
  import stlb_pkg::*;

  cmd_t             in_cmd;
  cmd_t             q_cmd;
  logic             q_valid;
  logic             q_ready;
  logic [LEN_W-1:0] len_r;

  assign in_cmd.action      = action_t'(in_action);
  assign in_cmd.entry_index = in_entry_index;
  assign in_cmd.value       = in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we) begin
      len_r <= cfg_table_length;
    end
  end

  stlb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  stlb_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .table_length (len_r),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_cmd        (q_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_position (out_position)
  );
endmodule

// File: bench/sorted_table_lower_bound_checker.sv
`timescale 1ns / 100ps

module sorted_table_lower_bound_checker
  import stlb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_action,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [VAL_W-1:0] in_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [LEN_W-1:0] out_position,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_table_length,
  output int               fail_count,
  output int               pending
);

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  logic [VAL_W-1:0] table_copy [DEPTH];
  logic [LEN_W-1:0] length_copy;
  logic [LEN_W-1:0] expected_positions[$];

  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  // map a float pattern to an unsigned key whose order follows the float order
  function automatic logic [31:0] order_key(input logic [31:0] f);
    if (f[30:0] == 31'd0) begin
      return 32'h8000_0000;
    end
    return f[31] ? ~f : (f | 32'h8000_0000);
  endfunction

  function automatic logic float_ge(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    return order_key(a) >= order_key(b);
  endfunction

  function automatic logic [LEN_W-1:0] lower_bound_of(input logic [31:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = (length_copy > DEPTH) ? DEPTH : length_copy;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (float_ge(table_copy[mid], key)) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return lo[LEN_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      length_copy = '0;
      expected_positions.delete();
    end else begin
      if (cfg_we) begin
        length_copy = cfg_table_length;
      end
      if (out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          $error("unexpected item: position actual %0d", out_position);
          fail_count++;
        end else begin
          if (out_position !== expected_positions[0]) begin
            $error("position mismatch: expected %0d actual %0d",
                   expected_positions[0], out_position);
            fail_count++;
          end
          void'(expected_positions.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        if (action_t'(in_action) == ACT_LOAD) begin
          if (in_entry_index < DEPTH) begin
            table_copy[in_entry_index] = in_value;
          end
        end else begin
          expected_positions.push_back(lower_bound_of(in_value));
        end
      end
    end
    pending = expected_positions.size();
  end

endmodule

// File: bench/tb_sorted_table_lower_bound.sv
`timescale 1ns / 100ps

module tb_sorted_table_lower_bound;
  import stlb_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 64;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_action;
  logic [IDX_W-1:0] in_entry_index;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic             out_ready;
  logic [LEN_W-1:0] out_position;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_table_length;
  int               fail_count;
  int               pending;
  logic             long_hold = 1'b0;
  int               burst_left = 0;
  logic [31:0]      row [DEPTH];
  logic             loaded [DEPTH];

  always #2 clk = ~clk;

  sorted_table_lower_bound dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_entry_index(in_entry_index), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_position(out_position),
    .cfg_we(cfg_we), .cfg_table_length(cfg_table_length)
  );

  sorted_table_lower_bound_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_entry_index(in_entry_index), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_position(out_position),
    .cfg_we(cfg_we), .cfg_table_length(cfg_table_length),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: stall pattern changes after each random span; long_hold forces a long stall
  initial begin
    int mode;
    int span;
    out_ready = 1'b0;
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        if (long_hold) break;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send(input action_t act, input logic [IDX_W-1:0] idx,
                      input logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_entry_index <= idx;
    in_value       <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we           <= 1'b1;
    cfg_table_length <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_float();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0000 | $urandom_range(0, 255);
      5: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // non-descending row built from ordered keys mapped back to float patterns, while the 32-bit key does not wrap
  task automatic build_sorted_row(input int n);
    logic [31:0] k;
    logic [31:0] f;
    k = $urandom_range(0, 32'h7000_0000);
    for (int i = 0; i < n; i++) begin
      k = k + $urandom_range(0, (i % 5 == 0) ? 0 : 32'h0100_0000);
      f = k[31] ? (k & 32'h7FFF_FFFF) : ~k;
      if (f[30:23] == 8'hFF && f[22:0] != 0) begin
        f = 32'h7F80_0000;
      end
      row[i] = f;
    end
  endtask

  task automatic load_row(input int n);
    for (int i = 0; i < n; i++) begin
      send(ACT_LOAD, i[IDX_W-1:0], row[i]);
    end
  endtask

  task automatic query_mix(input int n, input int len);
    logic [31:0] k;
    int p;
    for (int i = 0; i < n; i++) begin
      if (len > 0 && $urandom_range(0, 9) != 0 && len <= DEPTH) begin
        p = $urandom_range(0, len - 1);
        k = row[p];
        case ($urandom_range(0, 2))
          0: k = k + 1;
          1: k = k - 1;
          default: ;
        endcase
      end else begin
        k = random_float();
      end
      if (len > 0 && $urandom_range(0, 7) == 0) begin
        p = $urandom_range(0, (len > DEPTH ? DEPTH : len) - 1);
        row[p] = $urandom_range(0, 3) == 0 ? random_float() : row[p];
        send(ACT_LOAD, p[IDX_W-1:0], row[p]);
      end
      send(ACT_QUERY, IDX_W'($urandom), k);
    end
  endtask

  // load only the entries that a full-depth search for key visits
  task automatic load_path(input logic [31:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = DEPTH;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!loaded[mid]) begin
        send(ACT_LOAD, mid[IDX_W-1:0], row[mid]);
        loaded[mid] = 1'b1;
      end
      if (fp_ge(row[mid], key)) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
  endtask

  task automatic query_deep(input int n);
    logic [31:0] k;
    int p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        p = $urandom_range(0, DEPTH - 1);
        k = row[p];
      end else begin
        k = random_float();
      end
      load_path(k);
      send(ACT_QUERY, IDX_W'($urandom), k);
    end
  endtask

  initial begin
    int len;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_action        = 1'b0;
    in_entry_index   = '0;
    in_value         = '0;
    cfg_we           = 1'b0;
    cfg_table_length = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(ACT_QUERY, '1, 32'h3F80_0000);
    send(ACT_QUERY, '0, 32'h7FC0_0000);
    row[0] = 32'hFF80_0000; row[1] = 32'hBF80_0000;
    row[2] = 32'h8000_0000; row[3] = 32'h0000_0000;
    row[4] = 32'h3F80_0000; row[5] = 32'h3F80_0000;
    row[6] = 32'h4020_0000; row[7] = 32'h7F80_0000;
    load_row(8);
    send(ACT_LOAD, '1, 32'hFFFF_FFFF);
    set_length(LEN_W'(8));
    send(ACT_QUERY, '0, 32'hFFFF_FFFF);
    send(ACT_QUERY, '0, 32'h7FC0_0000);
    send(ACT_QUERY, '0, 32'hFF80_0000);
    send(ACT_QUERY, '0, 32'h7F80_0000);
    send(ACT_QUERY, '0, 32'h0000_0000);
    send(ACT_QUERY, '0, 32'h8000_0000);
    send(ACT_QUERY, '0, 32'h3F80_0000);
    send(ACT_QUERY, '0, 32'h4040_0000);
    send(ACT_QUERY, '0, 32'h0000_0001);
    send(ACT_QUERY, '0, 32'h7F7F_FFFF);
    send(ACT_QUERY, '0, 32'hFF7F_FFFF);
    send(ACT_LOAD, 10'd3, 32'h7FC0_0000);
    send(ACT_QUERY, '0, 32'h3F00_0000);
    send(ACT_QUERY, '0, 32'hBF00_0000);

    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 7)
        0: len = 1;
        1: len = 2;
        2: len = 3;
        3: len = $urandom_range(4, 20);
        4: len = $urandom_range(21, 40);
        5: len = 5;
        default: len = $urandom_range(65, 100);
      endcase
      if (ph == 9) begin
        for (int i = 0; i < len; i++) row[i] = random_float();
      end else begin
        build_sorted_row(len);
      end
      load_row(len);
      set_length(LEN_W'(len));
      if (ph == 4) begin
        long_hold = 1'b1;
      end
      query_mix(10, len);
    end

    build_sorted_row(DEPTH);
    for (int i = 0; i < DEPTH; i++) loaded[i] = 1'b0;
    set_length(LEN_W'(DEPTH));
    query_deep(8);
    set_length('1);
    query_deep(4);
    set_length('0);
    query_mix(4, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
